// ===== hdl/baro_sensor_compensation_defines.svh =====
// Assertion macros for the barometric compensation block.
// Used by every RTL file that carries concurrent assertions.
`ifndef BARO_SENSOR_COMPENSATION_DEFINES_SVH
`define BARO_SENSOR_COMPENSATION_DEFINES_SVH
`ifndef ASSERT_OFF
`define BSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BSC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BSC_ASSERT(lbl, prop, msg)
`define BSC_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== hdl/bsc_pkg.sv =====
// Types and constants for the barometric compensation block.
// No dependencies; imported by all block modules.
package bsc_pkg;
  localparam int unsigned AltScalingDef = 0;
  localparam int unsigned QueueDepthDef = 4;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 17;
  localparam int unsigned AccW = 47;

  localparam logic [CfgIdxW-1:0] RegC1 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegC2 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegC3 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegC4 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegC5 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegC6 = 3'd5;
  localparam logic [CfgIdxW-1:0] RegPTrim = 3'd6;
  localparam logic [CfgIdxW-1:0] RegTTrim = 3'd7;

  localparam logic signed [19:0] TempRef = 20'sd2000;
  localparam logic signed [19:0] TempLow = -20'sd1500;
  localparam logic signed [38:0] PresMin = -39'sd16777216;
  localparam logic signed [38:0] PresMax = 39'sd16777215;
  localparam logic signed [20:0] TOutMin = -21'sd32768;
  localparam logic signed [20:0] TOutMax = 21'sd32767;

  typedef struct packed {
    logic [23:0] pressure_raw;
    logic [23:0] temperature_raw;
    logic        second_order_enable;
  } in_word_t;

  typedef struct packed {
    logic signed [24:0] pressure;
    logic signed [15:0] temperature;
  } out_word_t;

  typedef struct packed {
    logic [23:0]        d1;
    logic signed [24:0] dt;
    logic               en;
  } job_t;

  typedef struct packed {
    logic [15:0]        c1;
    logic [15:0]        c2;
    logic [15:0]        c3;
    logic [15:0]        c4;
    logic [15:0]        c5;
    logic [15:0]        c6;
    logic signed [16:0] ptrim;
    logic signed [15:0] ttrim;
  } cal_t;
endpackage

// ===== hdl/baro_sensor_compensation.sv =====
// Barometric sensor compensation, top level: calibration registers,
// front end, job queue and datapath. Depends on bsc_pkg and bsc_* modules.
//
// Input channel in_valid_i/in_ready_o carries one word of raw pressure,
// raw temperature and the second-order enable. Output channel
// out_valid_o/out_ready_i returns one word of compensated pressure
// (0.01 mbar) and temperature (0.01 C), both trimmed and saturated.
// Calibration words are written through cfg_we_i/cfg_idx_i/cfg_wdata_i;
// the user must write them only while the block is idle, as the block
// does not enforce this. An accepted word passes the front register, a
// queue slot, then the eight datapath registers, the last being the
// output register. Throughput is one word per cycle while out_ready_i is
// high, set by the fully pipelined datapath. When out_ready_i is low with
// a result in the output register, the datapath holds; the queue and front
// register keep taking words until the queue fills, then in_ready_o drops.
// Reset clears all calibration registers to zero and empties the pipeline.
module baro_sensor_compensation import bsc_pkg::*; #(
  parameter int unsigned AltScaling = AltScalingDef,
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_word_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_word_t           out_word_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);
  cal_t cal_q;
  logic q_full, push, pop, q_valid;
  job_t job_f, job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegC1:    cal_q.c1    <= cfg_wdata_i[15:0];
        RegC2:    cal_q.c2    <= cfg_wdata_i[15:0];
        RegC3:    cal_q.c3    <= cfg_wdata_i[15:0];
        RegC4:    cal_q.c4    <= cfg_wdata_i[15:0];
        RegC5:    cal_q.c5    <= cfg_wdata_i[15:0];
        RegC6:    cal_q.c6    <= cfg_wdata_i[15:0];
        RegPTrim: cal_q.ptrim <= $signed(cfg_wdata_i[16:0]);
        RegTTrim: cal_q.ttrim <= $signed(cfg_wdata_i[15:0]);
        default: begin
        end
      endcase
    end
  end

  bsc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_word_i,
    .c5_i(cal_q.c5), .q_full_i(q_full), .push_o(push), .job_o(job_f)
  );

  bsc_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .job_i(job_f), .full_o(q_full),
    .pop_i(pop), .valid_o(q_valid), .job_o(job_q)
  );

  bsc_back #(.AltScaling(AltScaling)) u_back (
    .clk_i, .rst_ni, .cal_i(cal_q), .q_valid_i(q_valid), .job_i(job_q),
    .pop_o(pop), .out_valid_o, .out_ready_i, .out_word_o
  );
endmodule

// ===== hdl/bsc_front.sv =====
// Front end: accepts input words and forms the temperature difference.
// Depends on bsc_pkg.
module bsc_front import bsc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_word_t in_word_i,
  input  logic [15:0] c5_i,
  input  logic     q_full_i,
  output logic     push_o,
  output job_t     job_o
);
  logic v_q;
  job_t job_q, job_d;

  assign in_ready_o = !v_q || !q_full_i;
  assign push_o     = v_q && !q_full_i;

  always_comb begin
    job_d.d1 = in_word_i.pressure_raw;
    job_d.en = in_word_i.second_order_enable;
    job_d.dt = $signed({1'b0, in_word_i.temperature_raw}) - $signed({1'b0, c5_i, 8'h00});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      job_q <= job_d;
    end
  end

  assign job_o = job_q;
endmodule

// ===== hdl/bsc_queue.sv =====
// Short job queue between front end and datapath.
// Depends on bsc_pkg and the assertion macro header.
`include "baro_sensor_compensation_defines.svh"
module bsc_queue import bsc_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [CntW-1:0] count_q;
  logic do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + AW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + AW'(1);
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (!push_i && do_pop) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  `BSC_ASSERT(q_cnt_bound, count_q <= CntW'(Depth), "queue count beyond depth")
  `BSC_ASSERT(q_no_overrun, full_o |-> !push_i, "push into full queue")
  `BSC_ASSERT(q_cnt_inc, (push_i && !do_pop) |=> count_q == $past(count_q) + CntW'(1), "count slip")
  `BSC_ASSERT_RST(q_rst_empty, !rst_ni |-> count_q == '0, "queue not empty in reset")
endmodule

// ===== hdl/bsc_back.sv =====
// Compensation datapath: eight-stage pipeline with output register.
// Depends on bsc_pkg.
module bsc_back import bsc_pkg::*; #(
  parameter int unsigned AltScaling = AltScalingDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cal_t      cal_i,
  input  logic      q_valid_i,
  input  job_t      job_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);
  localparam int unsigned OS = (AltScaling != 0) ? 17 : 16;
  localparam int unsigned OD = (AltScaling != 0) ? 6 : 7;
  localparam int unsigned SS = (AltScaling != 0) ? 16 : 15;
  localparam int unsigned SD = (AltScaling != 0) ? 7 : 8;

  logic [8:1] v_q;
  logic adv;
  assign adv   = !v_q[8] || out_ready_i;
  assign pop_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[7:1], q_valid_i};
    end
  end

  // stage 1
  job_t s1_q;
  // stage 2
  logic [23:0] s2_d1_q; logic s2_en_q;
  logic signed [41:0] s2_mt_q, s2_mo_q, s2_ms_q;
  logic signed [49:0] s2_mdd_q;
  // stage 3
  logic [23:0] s3_d1_q; logic s3_en_q;
  logic signed [19:0] s3_temp_q, s3_t2_q, s3_temp_d;
  logic signed [AccW-1:0] s3_off_q, s3_sens_q, s3_off_d, s3_sens_d;
  logic [AccW-1:0] off_base, sens_base;
  // stage 4
  logic [23:0] s4_d1_q; logic s4_lo_q, s4_vlo_q;
  logic signed [19:0] s4_temp_q, s4_t2_q;
  logic signed [AccW-1:0] s4_off_q, s4_sens_q;
  logic signed [20:0] ta, tb;
  logic signed [41:0] s4_u_q, s4_v_q, u_d, v_d;
  // stage 5
  logic [23:0] s5_d1_q;
  logic signed [19:0] s5_temp_q;
  logic signed [AccW-1:0] s5_off_q, s5_sens_q;
  logic signed [45:0] s5_off2_q, s5_sens2_q, u46, v46, u5, off2_d, sens2_d;
  // stage 6
  logic [23:0] s6_d1_q;
  logic signed [19:0] s6_temp_q;
  logic signed [AccW-1:0] s6_off_q, s6_sens_q;
  // stage 7
  logic signed [19:0] s7_temp_q;
  logic signed [AccW-1:0] s7_off_q;
  logic signed [50:0] s7_ph_q;
  logic [44:0] s7_pl_q;
  logic signed [AccW-22:0] sh;
  logic [20:0] sl;
  // stage 8
  logic signed [52:0] acc;
  logic signed [38:0] pres;
  logic signed [20:0] tsum;
  out_word_t out_q, out_d;

  assign off_base  = AccW'(cal_i.c2) << OS;
  assign sens_base = AccW'(cal_i.c1) << SS;

  always_comb begin
    s3_temp_d = TempRef + 20'(s2_mt_q >>> 23);
    s3_off_d  = $signed(off_base) + AccW'(s2_mo_q >>> OD);
    s3_sens_d = $signed(sens_base) + AccW'(s2_ms_q >>> SD);
    ta   = 21'(s3_temp_q) - 21'(TempRef);
    tb   = 21'(s3_temp_q) - 21'(TempLow);
    u_d  = ta * ta;
    v_d  = tb * tb;
    u46  = 46'(s4_u_q);
    v46  = 46'(s4_v_q);
    u5   = (u46 <<< 2) + u46;
    off2_d  = (u5 >>> 1) + (s4_vlo_q ? (v46 <<< 3) - v46 : 46'sd0);
    sens2_d = (u5 >>> 2) +
              (s4_vlo_q ? ((v46 <<< 3) + (v46 <<< 1) + v46) >>> 1 : 46'sd0);
    sh   = s6_sens_q[AccW-1:21];
    sl   = s6_sens_q[20:0];
    acc  = 53'(s7_ph_q) + $signed(53'(s7_pl_q >> 21)) - 53'(s7_off_q);
    pres = 39'(acc >>> 15) + 39'(cal_i.ptrim);
    tsum = 21'(s7_temp_q) + 21'(cal_i.ttrim);
    if (pres < PresMin) begin
      out_d.pressure = 25'(PresMin);
    end else if (pres > PresMax) begin
      out_d.pressure = 25'(PresMax);
    end else begin
      out_d.pressure = 25'(pres);
    end
    if (tsum < TOutMin) begin
      out_d.temperature = 16'(TOutMin);
    end else if (tsum > TOutMax) begin
      out_d.temperature = 16'(TOutMax);
    end else begin
      out_d.temperature = 16'(tsum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q      <= job_i;
      s2_d1_q   <= s1_q.d1;
      s2_en_q   <= s1_q.en;
      s2_mt_q   <= s1_q.dt * $signed({1'b0, cal_i.c6});
      s2_mo_q   <= s1_q.dt * $signed({1'b0, cal_i.c4});
      s2_ms_q   <= s1_q.dt * $signed({1'b0, cal_i.c3});
      s2_mdd_q  <= s1_q.dt * s1_q.dt;
      s3_d1_q   <= s2_d1_q;
      s3_en_q   <= s2_en_q;
      s3_temp_q <= s3_temp_d;
      s3_t2_q   <= 20'(s2_mdd_q >>> 31);
      s3_off_q  <= s3_off_d;
      s3_sens_q <= s3_sens_d;
      s4_d1_q   <= s3_d1_q;
      s4_lo_q   <= s3_en_q && (s3_temp_q < TempRef);
      s4_vlo_q  <= s3_temp_q < TempLow;
      s4_temp_q <= s3_temp_q;
      s4_t2_q   <= s3_t2_q;
      s4_off_q  <= s3_off_q;
      s4_sens_q <= s3_sens_q;
      s4_u_q    <= u_d;
      s4_v_q    <= v_d;
      s5_d1_q   <= s4_d1_q;
      s5_temp_q <= s4_lo_q ? s4_temp_q - s4_t2_q : s4_temp_q;
      s5_off_q  <= s4_off_q;
      s5_sens_q <= s4_sens_q;
      s5_off2_q  <= s4_lo_q ? off2_d : 46'sd0;
      s5_sens2_q <= s4_lo_q ? sens2_d : 46'sd0;
      s6_d1_q   <= s5_d1_q;
      s6_temp_q <= s5_temp_q;
      s6_off_q  <= s5_off_q - AccW'(s5_off2_q);
      s6_sens_q <= s5_sens_q - AccW'(s5_sens2_q);
      s7_temp_q <= s6_temp_q;
      s7_off_q  <= s6_off_q;
      s7_ph_q   <= $signed({1'b0, s6_d1_q}) * sh;
      s7_pl_q   <= s6_d1_q * sl;
      out_q     <= out_d;
    end
  end

  assign out_valid_o = v_q[8];
  assign out_word_o  = out_q;
endmodule

// ===== tb/sv/baro_sensor_compensation_tb.sv =====
// Self-checking testbench for baro_sensor_compensation: random and directed
// conversion words against an in-bench model of the compensation formulas.
// Depends on bsc_pkg and the RTL top level.
module baro_sensor_compensation_tb import bsc_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles = 20;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  in_word_t            in_word_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_word_t           out_word_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  baro_sensor_compensation dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_word_o(out_word_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  cal_t      cal;
  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  int        error_count;
  int        idle_cycles;
  int        gap_left;
  int        burst_left;
  int        stall_phase;
  bit        hold_sender;

  function automatic longint floor_shift(longint v, int k);
    return v >>> k;
  endfunction

  function automatic out_word_t compensate(in_word_t w);
    longint d1, dt, tmp, off, sens, t2, u, off2, sens2, v, p;
    out_word_t r;
    d1 = longint'(w.pressure_raw);
    dt = longint'(w.temperature_raw) - longint'(cal.c5) * 256;
    tmp = 2000 + floor_shift(dt * longint'(cal.c6), 23);
    off = (longint'(cal.c2) <<< (AltScalingDef ? 17 : 16))
        + floor_shift(longint'(cal.c4) * dt, AltScalingDef ? 6 : 7);
    sens = (longint'(cal.c1) <<< (AltScalingDef ? 16 : 15))
         + floor_shift(longint'(cal.c3) * dt, AltScalingDef ? 7 : 8);
    if (w.second_order_enable && tmp < 2000) begin
      t2 = floor_shift(dt * dt, 31);
      u = (tmp - 2000) * (tmp - 2000);
      off2 = floor_shift(5 * u, 1);
      sens2 = floor_shift(5 * u, 2);
      if (tmp < -1500) begin
        v = (tmp + 1500) * (tmp + 1500);
        off2 += 7 * v;
        sens2 += floor_shift(11 * v, 1);
      end
      tmp -= t2;
      off -= off2;
      sens -= sens2;
    end
    p = floor_shift(floor_shift(d1 * sens, 21) - off, 15) + longint'(cal.ptrim);
    if (p < -16777216) p = -16777216;
    if (p > 16777215) p = 16777215;
    tmp += longint'(cal.ttrim);
    if (tmp < -32768) tmp = -32768;
    if (tmp > 32767) tmp = 32767;
    r.pressure = p[24:0];
    r.temperature = tmp[15:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    error_count++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value[CfgDataW-1:0];
    case (idx)
      RegC1: cal.c1 = value[15:0];
      RegC2: cal.c2 = value[15:0];
      RegC3: cal.c3 = value[15:0];
      RegC4: cal.c4 = value[15:0];
      RegC5: cal.c5 = value[15:0];
      RegC6: cal.c6 = value[15:0];
      RegPTrim: cal.ptrim = value[16:0];
      default: cal.ttrim = value[15:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_cal(int c1, int c2, int c3, int c4, int c5, int c6, int pt, int tt);
    write_reg(RegC1, c1);
    write_reg(RegC2, c2);
    write_reg(RegC3, c3);
    write_reg(RegC4, c4);
    write_reg(RegC5, c5);
    write_reg(RegC6, c6);
    write_reg(RegPTrim, pt);
    write_reg(RegTTrim, tt);
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid_i || expected_words.size() != 0)
      @(posedge clk_i);
  endtask

  function automatic in_word_t random_word();
    in_word_t w;
    int sel;
    sel = $urandom_range(0, 9);
    w.pressure_raw = (sel == 0) ? 24'hFFFFFF : (sel == 1) ? 24'd0 : 24'($urandom);
    sel = $urandom_range(0, 9);
    // mostly near the reference point so both low-temperature branches are hit
    if (sel < 6)
      w.temperature_raw = 24'(int'(cal.c5) * 256 + $urandom_range(0, 1 << 20) - (1 << 19));
    else if (sel == 6)
      w.temperature_raw = 24'hFFFFFF;
    else if (sel == 7)
      w.temperature_raw = 24'd0;
    else
      w.temperature_raw = 24'($urandom);
    w.second_order_enable = ($urandom_range(0, 3) != 0);
    return w;
  endfunction

  task automatic push_word(logic [23:0] p, logic [23:0] t, logic en);
    in_word_t w;
    w.pressure_raw = p;
    w.temperature_raw = t;
    w.second_order_enable = en;
    pending_words.push_back(w);
  endtask

  // driver: bursts and gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i <= '0;
      gap_left <= 0;
      burst_left <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_words.push_back(compensate(in_word_i));
        idle_cycles = 0;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() != 0 && !hold_sender) begin
          in_valid_i <= 1'b1;
          in_word_i <= pending_words.pop_front();
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_phase <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        idle_cycles = 0;
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", out_word_o.pressure, 0);
        end else begin
          want = expected_words.pop_front();
          if (out_word_o.pressure !== want.pressure)
            report_mismatch("pressure", out_word_o.pressure, want.pressure);
          if (out_word_o.temperature !== want.temperature)
            report_mismatch("temperature", out_word_o.temperature, want.temperature);
        end
      end
      stall_phase <= (stall_phase + 1) % 64;
      if (stall_phase < 24)
        out_ready_i <= 1'b1;
      else if (stall_phase < 40)
        out_ready_i <= (stall_phase % 3) != 0;
      else
        out_ready_i <= $urandom_range(0, 2) != 0;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("baro_sensor_compensation_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    cal = '0;
    error_count = 0;
    idle_cycles = 0;
    hold_sender = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset calibration: all zeros
    push_word(24'd0, 24'd0, 1'b1);
    push_word(24'hFFFFFF, 24'hFFFFFF, 1'b1);
    wait_idle();

    // typical datasheet-like calibration
    load_cal(40127, 36924, 23317, 23282, 33464, 28312, 0, 0);
    push_word(24'd9085466, 24'd8569150, 1'b1);
    push_word(24'd9085466, 24'd8569150, 1'b0);
    push_word(24'd9085466, 24'd7000000, 1'b1);
    push_word(24'd9085466, 24'd7000000, 1'b0);
    push_word(24'd9085466, 24'd5000000, 1'b1);
    push_word(24'd9085466, 24'd0, 1'b1);
    push_word(24'hFFFFFF, 24'hFFFFFF, 1'b1);
    push_word(24'd0, 24'd0, 1'b0);
    push_word(24'd0, 24'hFFFFFF, 1'b1);
    push_word(24'hFFFFFF, 24'd0, 1'b0);
    wait_idle();

    // extremes: all ones and maximal trims, then minimal trims
    load_cal(65535, 65535, 65535, 65535, 65535, 65535, 65535, 32767);
    push_word(24'hFFFFFF, 24'hFFFFFF, 1'b1);
    push_word(24'hFFFFFF, 24'd0, 1'b1);
    push_word(24'd0, 24'd0, 1'b0);
    push_word(24'h800000, 24'h7FFFFF, 1'b1);
    wait_idle();
    write_reg(RegPTrim, -65536);
    write_reg(RegTTrim, -32768);
    push_word(24'hFFFFFF, 24'hFFFFFF, 1'b1);
    push_word(24'hFFFFFF, 24'd0, 1'b1);
    push_word(24'd0, 24'd0, 1'b1);
    push_word(24'h555555, 24'hAAAAAA, 1'b0);
    wait_idle();

    // random phases, each with fresh calibration
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7)
        load_cal(0, 0, 0, 0, 0, 0, 0, 0);
      else
        load_cal($urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 131071) - 65536, $urandom_range(0, 65535) - 32768);
      for (int i = 0; i < 200; i++) begin
        pending_words.push_back(random_word());
        if (i == 100) begin
          // sender pause until everything has drained
          while (pending_words.size() > 1 || in_valid_i) @(posedge clk_i);
          hold_sender = 1'b1;
          while (expected_words.size() != 0) @(posedge clk_i);
          hold_sender = 1'b0;
        end
      end
      wait_idle();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0)
      $display("baro_sensor_compensation_tb: done, clean");
    else
      $display("baro_sensor_compensation_tb: done, errors");
    $finish;
  end
endmodule
